FILE: hdl/vxlan_pkg.sv
// ----------------------------------------------------------------------------
// VXLAN encapsulation package
// Shared types, constants and the outer header byte table.
// ----------------------------------------------------------------------------
package vxlan_pkg;

  localparam int HEADER_BYTES  = 50;
  localparam int MAX_INNER_LEN = 16383;
  localparam int QUEUE_DEPTH   = 4;

  localparam int IDX_W   = 6;   // header byte index, 0..HEADER_BYTES
  localparam int SUM_W   = 20;  // checksum accumulator
  localparam int LEN_W   = 14;
  localparam int CFG_W   = 48;
  localparam int REG_W   = 3;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
  localparam logic [7:0]  IP_TTL         = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] VXLAN_PORT     = 16'd4789;
  localparam logic [7:0]  VXLAN_FLAG_I   = 8'h08;
  localparam logic [15:0] IP_AFTER_ETH   = 16'd36;
  localparam logic [15:0] UDP_AFTER_IP   = 16'd16;

  // fixed words of the IPv4 header that enter the checksum
  localparam logic [SUM_W-1:0] IP_FIXED_SUM =
      SUM_W'({IP_VER_IHL, 8'h00}) + SUM_W'(IP_FLAGS_DF) +
      SUM_W'({IP_TTL, IP_PROTO_UDP}) + SUM_W'(IP_AFTER_ETH);

  typedef enum logic [REG_W-1:0] {
    REG_DEST_MAC   = 3'd0,
    REG_SOURCE_MAC = 3'd1,
    REG_SOURCE_IP  = 3'd2,
    REG_DEST_IP    = 3'd3,
    REG_UDP_PORT   = 3'd4,
    REG_NETWORK_ID = 3'd5,
    REG_CAPACITY   = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_PAYLOAD = 2'd0,
    CMD_HEADER  = 2'd1,
    CMD_ERROR   = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_HEADER = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] frame_length;
    logic [15:0]      ip_ident;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       error_flag;
  } out_item_t;

  typedef struct packed {
    logic [47:0] outer_dest_mac;
    logic [47:0] outer_source_mac;
    logic [31:0] outer_source_ip;
    logic [31:0] outer_dest_ip;
    logic [15:0] udp_source_port;
    logic [23:0] network_id;
    logic [15:0] output_capacity;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       payload_byte;
    logic             last;
    logic [LEN_W-1:0] frame_length;
    logic [15:0]      ip_ident;
    logic [SUM_W-1:0] part_sum;
  } cmd_t;

  // One byte of the 50-byte outer header.
  function automatic logic [7:0] header_byte(
      input logic [IDX_W-1:0] idx,
      input cfg_t             cfg,
      input logic [LEN_W-1:0] len,
      input logic [15:0]      ident,
      input logic [15:0]      csum);
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [7:0]  b;
    ip_len  = IP_AFTER_ETH + 16'(len);
    udp_len = UDP_AFTER_IP + 16'(len);
    case (idx)
      6'd0:  b = cfg.outer_dest_mac[47:40];
      6'd1:  b = cfg.outer_dest_mac[39:32];
      6'd2:  b = cfg.outer_dest_mac[31:24];
      6'd3:  b = cfg.outer_dest_mac[23:16];
      6'd4:  b = cfg.outer_dest_mac[15:8];
      6'd5:  b = cfg.outer_dest_mac[7:0];
      6'd6:  b = cfg.outer_source_mac[47:40];
      6'd7:  b = cfg.outer_source_mac[39:32];
      6'd8:  b = cfg.outer_source_mac[31:24];
      6'd9:  b = cfg.outer_source_mac[23:16];
      6'd10: b = cfg.outer_source_mac[15:8];
      6'd11: b = cfg.outer_source_mac[7:0];
      6'd12: b = ETHERTYPE_IPV4[15:8];
      6'd13: b = ETHERTYPE_IPV4[7:0];
      6'd14: b = IP_VER_IHL;
      6'd16: b = ip_len[15:8];
      6'd17: b = ip_len[7:0];
      6'd18: b = ident[15:8];
      6'd19: b = ident[7:0];
      6'd20: b = IP_FLAGS_DF[15:8];
      6'd21: b = IP_FLAGS_DF[7:0];
      6'd22: b = IP_TTL;
      6'd23: b = IP_PROTO_UDP;
      6'd24: b = csum[15:8];
      6'd25: b = csum[7:0];
      6'd26: b = cfg.outer_source_ip[31:24];
      6'd27: b = cfg.outer_source_ip[23:16];
      6'd28: b = cfg.outer_source_ip[15:8];
      6'd29: b = cfg.outer_source_ip[7:0];
      6'd30: b = cfg.outer_dest_ip[31:24];
      6'd31: b = cfg.outer_dest_ip[23:16];
      6'd32: b = cfg.outer_dest_ip[15:8];
      6'd33: b = cfg.outer_dest_ip[7:0];
      6'd34: b = cfg.udp_source_port[15:8];
      6'd35: b = cfg.udp_source_port[7:0];
      6'd36: b = VXLAN_PORT[15:8];
      6'd37: b = VXLAN_PORT[7:0];
      6'd38: b = udp_len[15:8];
      6'd39: b = udp_len[7:0];
      6'd42: b = VXLAN_FLAG_I;
      6'd46: b = cfg.network_id[23:16];
      6'd47: b = cfg.network_id[15:8];
      6'd48: b = cfg.network_id[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/vxlan_front.sv
// ----------------------------------------------------------------------------
// VXLAN front end
// Accepts input bytes, tracks frame boundaries and turns each into a command,
// except the bytes of a rejected frame after its first.
module vxlan_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vxlan_pkg::in_item_t in_data,
  input  logic [15:0]         capacity,
  output logic                push,
  output vxlan_pkg::cmd_t     push_cmd,
  input  logic                queue_full
);

  logic [vxlan_pkg::LEN_W-1:0] bytes_remaining;
  logic [vxlan_pkg::LEN_W-1:0] bytes_remaining_next;
  logic                        dropping;
  logic                        dropping_next;
  logic                        accept;
  logic                        too_big;
  logic [vxlan_pkg::LEN_W-1:0] len;
  logic [vxlan_pkg::LEN_W-1:0] rem_dec;
  logic [vxlan_pkg::LEN_W-1:0] len_dec;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign len      = in_data.frame_length;
  assign rem_dec  = bytes_remaining - 1'b1;
  assign len_dec  = (len != '0) ? len - 1'b1 : '0;
  assign too_big  = (17'(len) > 17'(vxlan_pkg::MAX_INNER_LEN)) ||
                    (17'(vxlan_pkg::HEADER_BYTES) + 17'(len) > 17'(capacity));

  always_comb begin
    bytes_remaining_next  = bytes_remaining;
    dropping_next         = dropping;
    push                  = 1'b0;
    push_cmd.kind         = vxlan_pkg::CMD_PAYLOAD;
    push_cmd.payload_byte = in_data.payload_byte;
    push_cmd.last         = 1'b0;
    push_cmd.frame_length = len;
    push_cmd.ip_ident     = in_data.ip_ident;
    push_cmd.part_sum     = vxlan_pkg::IP_FIXED_SUM + vxlan_pkg::SUM_W'(len) +
                            vxlan_pkg::SUM_W'(in_data.ip_ident);
    if (accept) begin
      if (bytes_remaining != '0) begin
        // inside a frame: pass the byte or swallow it
        bytes_remaining_next = rem_dec;
        if (dropping) begin
          if (rem_dec == '0) begin
            dropping_next = 1'b0;
          end
        end else begin
          push          = 1'b1;
          push_cmd.last = (rem_dec == '0);
        end
      end else begin
        push                 = 1'b1;
        bytes_remaining_next = len_dec;
        push_cmd.last        = (len == vxlan_pkg::LEN_W'(1));
        if (too_big) begin
          push_cmd.kind = vxlan_pkg::CMD_ERROR;
          dropping_next = (len_dec != '0);
        end else begin
          push_cmd.kind = vxlan_pkg::CMD_HEADER;
          dropping_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      dropping        <= 1'b0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      dropping        <= dropping_next;
    end
  end

endmodule

FILE: hdl/vxlan_queue.sv
// ----------------------------------------------------------------------------
// VXLAN command queue
// Short FIFO of commands between the front end and the byte generator.
// ----------------------------------------------------------------------------
module vxlan_queue #(
  parameter int DEPTH = vxlan_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vxlan_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output vxlan_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vxlan_pkg::cmd_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/vxlan_back.sv
// ----------------------------------------------------------------------------
// VXLAN back end
// Executes commands: streams the outer header, payload bytes and errors.
// ----------------------------------------------------------------------------
module vxlan_back (
  input  logic                 clk,
  input  logic                 rst,
  input  vxlan_pkg::cfg_t      cfg,
  input  logic                 cmd_valid,
  input  vxlan_pkg::cmd_t      cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vxlan_pkg::out_item_t out_data
);

  localparam int SW = vxlan_pkg::SUM_W;

  vxlan_pkg::back_state_t        state;
  vxlan_pkg::back_state_t        state_next;
  vxlan_pkg::cmd_t               cur;
  vxlan_pkg::cmd_t               cur_next;
  logic [vxlan_pkg::IDX_W-1:0]   idx;
  logic [vxlan_pkg::IDX_W-1:0]   idx_next;
  logic [SW-1:0]                 hsum;
  logic [SW-1:0]                 hsum_next;
  logic [1:0]                    ck_step;
  logic [1:0]                    ck_step_next;
  logic                          out_valid_next;
  vxlan_pkg::out_item_t          out_data_next;
  logic                          adv;
  logic [15:0]                   csum;
  logic                          hdr_end;

  assign adv     = !out_valid || out_ready;
  assign csum    = ~hsum[15:0];
  assign hdr_end = (idx == vxlan_pkg::IDX_W'(vxlan_pkg::HEADER_BYTES - 1));

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    idx_next       = idx;
    hsum_next      = hsum;
    ck_step_next   = ck_step;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    cmd_pop        = 1'b0;
    if (adv) begin
      out_valid_next = 1'b0;
    end
    case (state)
      vxlan_pkg::BK_IDLE: begin
        if (adv && cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            vxlan_pkg::CMD_PAYLOAD: begin
              out_valid_next         = 1'b1;
              out_data_next.out_byte   = cmd.payload_byte;
              out_data_next.out_last   = cmd.last;
              out_data_next.error_flag = 1'b0;
            end
            vxlan_pkg::CMD_ERROR: begin
              out_valid_next           = 1'b1;
              out_data_next.out_byte   = 8'h00;
              out_data_next.out_last   = 1'b1;
              out_data_next.error_flag = 1'b1;
            end
            vxlan_pkg::CMD_HEADER: begin
              // load the frame and seed the checksum with the source address
              cur_next     = cmd;
              idx_next     = '0;
              ck_step_next = '0;
              hsum_next    = cmd.part_sum + SW'(cfg.outer_source_ip[31:16]) +
                             SW'(cfg.outer_source_ip[15:0]);
              state_next   = vxlan_pkg::BK_HEADER;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      vxlan_pkg::BK_HEADER: begin
        // finish the checksum long before its bytes go out
        case (ck_step)
          2'd0: hsum_next = hsum + SW'(cfg.outer_dest_ip[31:16]) +
                            SW'(cfg.outer_dest_ip[15:0]);
          2'd1, 2'd2: hsum_next = SW'(hsum[15:0]) + SW'(hsum[SW-1:16]);
          default: hsum_next = hsum;
        endcase
        if (ck_step != 2'd3) begin
          ck_step_next = ck_step + 1'b1;
        end
        if (adv) begin
          out_valid_next = 1'b1;
          if (idx == vxlan_pkg::IDX_W'(vxlan_pkg::HEADER_BYTES)) begin
            // first payload byte follows the header
            out_data_next.out_byte   = cur.payload_byte;
            out_data_next.out_last   = cur.last;
            out_data_next.error_flag = 1'b0;
            state_next               = vxlan_pkg::BK_IDLE;
          end else begin
            out_data_next.out_byte   = vxlan_pkg::header_byte(idx, cfg, cur.frame_length,
                                                              cur.ip_ident, csum);
            out_data_next.out_last   = hdr_end && (cur.frame_length == '0);
            out_data_next.error_flag = 1'b0;
            idx_next                 = idx + 1'b1;
            if (hdr_end && (cur.frame_length == '0)) begin
              state_next = vxlan_pkg::BK_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = vxlan_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vxlan_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    idx      <= idx_next;
    hsum     <= hsum_next;
    ck_step  <= ck_step_next;
    out_data <= out_data_next;
  end

endmodule

FILE: hdl/vxlan_encap_header_inserter.sv
// ----------------------------------------------------------------------------
// VXLAN encapsulation header inserter
// Wraps inner Ethernet frames in Ethernet/IPv4/UDP/VXLAN outer headers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one inner frame
//   byte per transaction; the first transaction of a frame also carries the
//   frame length and the IPv4 identification. The output channel
//   (out_valid/out_ready/out_data) carries one encapsulated byte per
//   transaction, out_last marking the end of a frame or an error.
//   Each frame starts with the 50 header bytes (Ethernet, IPv4 with its
//   checksum, UDP, VXLAN); payload then flows at one byte per cycle while
//   out_ready is high. A frame that does not fit output_capacity yields one
//   error transaction and its remaining input bytes are consumed silently.
//   A payload byte passes through the command queue and the output
//   register; a header passes through the queue, the back end's header
//   state and the output register. Steady state moves one input and one
//   output byte per cycle; for each frame the back end first pops the header
//   command without output, then streams the header one byte per cycle.
//   The command queue lets input run ahead while the header goes out; when
//   it fills, in_ready drops. A stall on out_ready holds the output register
//   and backs up into the queue, then the input.
//   Reset clears frame tracking, the queue and the output; the configuration
//   registers return to zero, output_capacity to 65535.
// ----------------------------------------------------------------------------
module vxlan_encap_header_inserter #(
  parameter int QUEUE_DEPTH = vxlan_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [vxlan_pkg::REG_W-1:0]   cfg_index,
  input  logic [vxlan_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vxlan_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vxlan_pkg::out_item_t          out_data
);

  vxlan_pkg::cfg_t cfg;
  vxlan_pkg::cfg_t cfg_next;
  logic            push;
  vxlan_pkg::cmd_t push_cmd;
  logic            queue_full;
  logic            cmd_pop;
  logic            cmd_valid;
  vxlan_pkg::cmd_t cmd;

  // Configuration registers: take the write, truncate to register width.
  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      case (cfg_index)
        vxlan_pkg::REG_DEST_MAC:   cfg_next.outer_dest_mac   = cfg_data;
        vxlan_pkg::REG_SOURCE_MAC: cfg_next.outer_source_mac = cfg_data;
        vxlan_pkg::REG_SOURCE_IP:  cfg_next.outer_source_ip  = cfg_data[31:0];
        vxlan_pkg::REG_DEST_IP:    cfg_next.outer_dest_ip    = cfg_data[31:0];
        vxlan_pkg::REG_UDP_PORT:   cfg_next.udp_source_port  = cfg_data[15:0];
        vxlan_pkg::REG_NETWORK_ID: cfg_next.network_id       = cfg_data[23:0];
        vxlan_pkg::REG_CAPACITY:   cfg_next.output_capacity  = cfg_data[15:0];
        default:                   cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{outer_dest_mac:   '0,
               outer_source_mac: '0,
               outer_source_ip:  '0,
               outer_dest_ip:    '0,
               udp_source_port:  '0,
               network_id:       '0,
               output_capacity:  16'hffff};
    end else begin
      cfg <= cfg_next;
    end
  end

  // Front end: frame tracking and classification.
  vxlan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .capacity   (cfg.output_capacity),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  // Decouple input from header generation.
  vxlan_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (cmd_pop),
    .pop_valid (cmd_valid),
    .pop_cmd   (cmd)
  );

  // Back end: header, payload and error bytes into the output register.
  vxlan_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VXLAN header inserter testbench
// Streams inner frames through the block under random back-pressure and input
// gaps, predicts every encapsulated byte from a local model of the header
// layout, the capacity check and the frame tracking, and compares each output
// transaction field by field with the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb;

  // Outer header layout, kept local so a bad package constant shows up.
  localparam int          OUTER_HDR_BYTES = 50;
  localparam logic [15:0] ETH_IPV4        = 16'h0800;
  localparam logic [7:0]  V4_VER_IHL      = 8'h45;
  localparam logic [15:0] V4_DONT_FRAG    = 16'h4000;
  localparam logic [7:0]  V4_TTL          = 8'd64;
  localparam logic [7:0]  V4_PROTO_UDP    = 8'd17;
  localparam logic [15:0] V4_LEN_BIAS     = 16'd36;
  localparam logic [15:0] UDP_LEN_BIAS    = 16'd16;
  localparam logic [15:0] VXLAN_DPORT     = 16'd4789;
  localparam logic [7:0]  VXLAN_I_FLAG    = 8'h08;

  // Register index past the end of the map; writes to it must be ignored.
  localparam logic [vxlan_pkg::REG_W-1:0] REG_SPARE = 3'd7;

  localparam int DRAIN_CYCLES   = 16;   // pipeline plus command queue, with margin
  localparam int WATCHDOG_LIMIT = 1000; // cycles without any transaction
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_FRAME     = 220;  // IPv4 total length reaches 0x0100
  localparam int PHASE_ITEMS    = 16;   // input transactions per random phase

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [vxlan_pkg::REG_W-1:0]   cfg_index = '0;
  logic [vxlan_pkg::CFG_W-1:0]   cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  vxlan_pkg::in_item_t           in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  vxlan_pkg::out_item_t          out_data;

  // Local copy of the register file and of the frame tracking.
  vxlan_pkg::cfg_t      link_cfg;
  logic [13:0]          inner_left = '0;
  logic                 discarding = 1'b0;
  vxlan_pkg::out_item_t expected_bytes[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int in_gap_pct     = 0;   // chance that an input transaction is preceded by a gap
  int out_stall_pct  = 0;   // chance per cycle that a sink stall burst starts
  int stall_left     = 0;

  vxlan_encap_header_inserter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Folded ones-complement sum of the ten IPv4 header words, checksum word zero.
  function automatic logic [15:0] ipv4_word_sum(input logic [13:0] len,
                                                 input logic [15:0] ident);
    logic [19:0] acc;
    acc = 20'({V4_VER_IHL, 8'h00}) + 20'(V4_LEN_BIAS + 16'(len)) + 20'(ident) +
          20'(V4_DONT_FRAG) + 20'({V4_TTL, V4_PROTO_UDP}) +
          20'(link_cfg.outer_source_ip[31:16]) + 20'(link_cfg.outer_source_ip[15:0]) +
          20'(link_cfg.outer_dest_ip[31:16]) + 20'(link_cfg.outer_dest_ip[15:0]);
    while (acc > 20'hFFFF) acc = (acc & 20'hFFFF) + (acc >> 16);
    return acc[15:0];
  endfunction

  function automatic bit frame_fits(input int len);
    return OUTER_HDR_BYTES + len <= int'(link_cfg.output_capacity);
  endfunction

  task automatic expect_byte(input logic [7:0] b, input logic last, input logic err);
    vxlan_pkg::out_item_t r;
    r.out_byte   = b;
    r.out_last   = last;
    r.error_flag = err;
    expected_bytes.push_back(r);
  endtask

  // Work out the encapsulated bytes that one accepted input transaction causes.
  task automatic encapsulate(input vxlan_pkg::in_item_t item);
    logic [7:0]  hdr [OUTER_HDR_BYTES];
    logic [13:0] len;
    logic [15:0] v4_total;
    logic [15:0] udp_total;
    logic [15:0] csum;
    len = item.frame_length;
    // Mid-frame: pass the byte through, or swallow it for a rejected frame.
    if (inner_left != 0) begin
      inner_left = inner_left - 1'b1;
      if (discarding) begin
        if (inner_left == 0) discarding = 1'b0;
        return;
      end
      expect_byte(item.payload_byte, inner_left == 0, 1'b0);
      return;
    end
    discarding = 1'b0;
    // Too big for the output: one error byte, then drop the rest of the frame.
    if (!frame_fits(int'(len))) begin
      expect_byte(8'h00, 1'b1, 1'b1);
      if (len != 0) begin
        inner_left = len - 1'b1;
        discarding = (inner_left != 0);
      end
      return;
    end
    v4_total  = V4_LEN_BIAS + 16'(len);
    udp_total = UDP_LEN_BIAS + 16'(len);
    csum      = ~ipv4_word_sum(len, item.ip_ident);
    foreach (hdr[k]) hdr[k] = 8'h00;
    for (int k = 0; k < 6; k++) begin
      hdr[k]     = link_cfg.outer_dest_mac[8*(5-k) +: 8];
      hdr[6 + k] = link_cfg.outer_source_mac[8*(5-k) +: 8];
    end
    {hdr[12], hdr[13]} = ETH_IPV4;
    hdr[14]            = V4_VER_IHL;
    {hdr[16], hdr[17]} = v4_total;
    {hdr[18], hdr[19]} = item.ip_ident;
    {hdr[20], hdr[21]} = V4_DONT_FRAG;
    hdr[22]            = V4_TTL;
    hdr[23]            = V4_PROTO_UDP;
    {hdr[24], hdr[25]} = csum;
    {hdr[26], hdr[27], hdr[28], hdr[29]} = link_cfg.outer_source_ip;
    {hdr[30], hdr[31], hdr[32], hdr[33]} = link_cfg.outer_dest_ip;
    {hdr[34], hdr[35]} = link_cfg.udp_source_port;
    {hdr[36], hdr[37]} = VXLAN_DPORT;
    {hdr[38], hdr[39]} = udp_total;
    hdr[42]            = VXLAN_I_FLAG;
    {hdr[46], hdr[47], hdr[48]} = link_cfg.network_id;
    // An empty frame ends on the last header byte.
    for (int k = 0; k < OUTER_HDR_BYTES; k++)
      expect_byte(hdr[k], (len == 0) && (k == OUTER_HDR_BYTES - 1), 1'b0);
    if (len != 0) begin
      inner_left = len - 1'b1;
      expect_byte(item.payload_byte, inner_left == 0, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string tag, input vxlan_pkg::out_item_t want,
                                 input vxlan_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%s: expected byte %02h last %b err %b, got byte %02h last %b err %b",
               tag, want.out_byte, want.out_last, want.error_flag,
               got.out_byte, got.out_last, got.error_flag);
  endtask

  task automatic check_result(input vxlan_pkg::out_item_t got);
    vxlan_pkg::out_item_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch("output with nothing pending", '0, got);
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
          got.error_flag !== want.error_flag)
        report_mismatch("output mismatch", want, got);
    end
  endtask

  // Sample both channels at the rising edge; predict before checking so the
  // queue order never depends on process scheduling.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) encapsulate(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d bytes pending", expected_bytes.size());
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Sink: drop out_ready in bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  = 1'b0;
      stall_left = stall_left - 1;
    end else if (out_stall_pct > 0 && $urandom_range(1, 100) <= out_stall_pct) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_ready = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  task automatic write_reg(input logic [vxlan_pkg::REG_W-1:0] idx,
                           input logic [vxlan_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      vxlan_pkg::REG_DEST_MAC:   link_cfg.outer_dest_mac   = value;
      vxlan_pkg::REG_SOURCE_MAC: link_cfg.outer_source_mac = value;
      vxlan_pkg::REG_SOURCE_IP:  link_cfg.outer_source_ip  = value[31:0];
      vxlan_pkg::REG_DEST_IP:    link_cfg.outer_dest_ip    = value[31:0];
      vxlan_pkg::REG_UDP_PORT:   link_cfg.udp_source_port  = value[15:0];
      vxlan_pkg::REG_NETWORK_ID: link_cfg.network_id       = value[23:0];
      vxlan_pkg::REG_CAPACITY:   link_cfg.output_capacity  = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Present one input transaction and hold it until accepted.
  task automatic send_item(input vxlan_pkg::in_item_t item);
    int gap;
    @(negedge clk);
    if (in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      gap      = $urandom_range(1, 15);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send a whole frame; fill < 0 means random payload. Fields of later
  // transactions are don't-care, so randomize them.
  task automatic send_frame(input int len, input logic [15:0] ident, input int fill);
    vxlan_pkg::in_item_t item;
    int                  count;
    count = (len == 0) ? 1 : len;
    for (int i = 0; i < count; i++) begin
      item.payload_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == 0) begin
        item.frame_length = 14'(len);
        item.ip_ident     = ident;
      end else begin
        item.frame_length = 14'($urandom);
        item.ip_ident     = 16'($urandom);
      end
      send_item(item);
    end
  endtask

  // Release the input, wait for every predicted byte, then let the pipeline
  // empty so a register write cannot hit a frame in flight.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [vxlan_pkg::CFG_W-1:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic randomize_config();
    logic [vxlan_pkg::CFG_W-1:0] cap;
    write_reg(vxlan_pkg::REG_DEST_MAC,   pick_reg_value());
    write_reg(vxlan_pkg::REG_SOURCE_MAC, pick_reg_value());
    write_reg(vxlan_pkg::REG_SOURCE_IP,  pick_reg_value());
    write_reg(vxlan_pkg::REG_DEST_IP,    pick_reg_value());
    write_reg(vxlan_pkg::REG_UDP_PORT,   pick_reg_value());
    write_reg(vxlan_pkg::REG_NETWORK_ID, pick_reg_value());
    // Mostly roomy; sometimes tight enough that short frames get rejected.
    case ($urandom_range(0, 3))
      0, 1:    cap = 48'hFFFF;
      2:       cap = 48'(OUTER_HDR_BYTES + $urandom_range(0, 64));
      default: cap = {16'($urandom), 32'($urandom)};
    endcase
    write_reg(vxlan_pkg::REG_CAPACITY, cap);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(1, 16);
    if (r < 92) return $urandom_range(17, 64);
    return $urandom_range(65, 200);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: all-zero addresses, full capacity.
  task automatic test_default_config();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    send_frame(0, 16'h0000, 8'hFF);
    send_frame(1, 16'h1234, 8'h00);
    send_frame(3, 16'hFFFF, -1);
    settle();
  endtask

  // Write all-ones through the full data width, so each register keeps only
  // its own bits, and poke the unused index.
  task automatic test_register_extremes();
    in_gap_pct    = 10;
    out_stall_pct = 10;
    write_reg(vxlan_pkg::REG_DEST_MAC,   '1);
    write_reg(vxlan_pkg::REG_SOURCE_MAC, '1);
    write_reg(vxlan_pkg::REG_SOURCE_IP,  '1);
    write_reg(vxlan_pkg::REG_DEST_IP,    '1);
    write_reg(vxlan_pkg::REG_UDP_PORT,   '1);
    write_reg(vxlan_pkg::REG_NETWORK_ID, '1);
    write_reg(vxlan_pkg::REG_CAPACITY,   '1);
    write_reg(REG_SPARE,      '0);
    send_frame(0, 16'hFFFF, 8'hA5);
    send_frame(1, 16'h0000, 8'hFF);
    send_frame(2, 16'hFFFF, 8'h00);
    settle();
    write_reg(REG_SPARE, '1);
    send_frame(2, 16'h8001, -1);
    settle();
  endtask

  // Pick the identification so the header words sum to 0xffff: checksum zero.
  task automatic test_checksum_fold();
    write_reg(vxlan_pkg::REG_SOURCE_IP, 48'hFFFF_FFFF);
    write_reg(vxlan_pkg::REG_DEST_IP,   48'hFFFE_0001);
    send_frame(5, ~ipv4_word_sum(14'd5, 16'h0000), -1);
    send_frame(0, ~ipv4_word_sum(14'd0, 16'h0000), -1);
    settle();
    write_reg(vxlan_pkg::REG_SOURCE_IP, '0);
    write_reg(vxlan_pkg::REG_DEST_IP,   '0);
    send_frame(1, ~ipv4_word_sum(14'd1, 16'h0000), -1);
    settle();
  endtask

  // Totals right at and just past output_capacity; rejected frames of one and
  // of several bytes, with good frames after them.
  task automatic test_capacity_edges();
    write_reg(vxlan_pkg::REG_CAPACITY, 48'(OUTER_HDR_BYTES));
    send_frame(0, 16'h0101, -1);
    send_frame(1, 16'h0202, -1);
    settle();
    write_reg(vxlan_pkg::REG_CAPACITY, 48'(OUTER_HDR_BYTES + 3));
    send_frame(3, 16'h0303, -1);
    send_frame(4, 16'h0404, -1);
    send_frame(2, 16'h0505, -1);
    settle();
    write_reg(vxlan_pkg::REG_CAPACITY, '0);
    send_frame(0, 16'h0606, -1);
    send_frame(2, 16'h0707, -1);
    send_frame(1, 16'h0808, -1);
    settle();
  endtask

  // Longest frame of the run, carried at exactly the capacity; its IPv4
  // total length carries into the high byte.
  task automatic test_longest_frames();
    in_gap_pct    = 3;
    out_stall_pct = 3;
    write_reg(vxlan_pkg::REG_CAPACITY, 48'(OUTER_HDR_BYTES + LONG_FRAME));
    send_frame(LONG_FRAME, 16'hC3C3, -1);
    settle();
  endtask

  // Phases of random frames under fresh settings; the last phase runs flat out.
  task automatic test_random_traffic();
    int budget;
    int len;
    for (int phase = 0; phase < 6; phase++) begin
      randomize_config();
      if (phase == 5) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = $urandom_range(0, 25);
        out_stall_pct = $urandom_range(0, 25);
      end
      budget = 0;
      while (budget < PHASE_ITEMS) begin
        len = pick_length();
        // Clip the frame to the input transactions left in this phase.
        if (len > PHASE_ITEMS - budget) len = PHASE_ITEMS - budget;
        budget += (len == 0) ? 1 : len;
        send_frame(len, 16'($urandom), -1);
      end
      settle();
    end
  endtask

  initial begin
    link_cfg                 = '0;
    link_cfg.output_capacity = 16'hFFFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_config();
    test_register_extremes();
    test_checksum_fold();
    test_capacity_edges();
    test_longest_frames();
    test_random_traffic();

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
